// File: rtl/irsf_pkg.sv
// ----------------------------------------------------------------------------
// irsf_pkg: shared types and constants for the IR sensor scan filter
// Field widths, register indexes, opcodes and the divider request/response.
// ----------------------------------------------------------------------------
`default_nettype none

package irsf_pkg;

  localparam int NUM_SENSORS = 3;
  localparam int DIST_W      = 16;
  localparam int RAW_W       = 12;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;

  // Serial divider operand widths: numerator scaled by 256, divisor is
  // sample plus offset with one carry bit.
  localparam int DVD_W       = 24;
  localparam int DVR_W       = 13;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SETTLE = 2'd0;
  localparam logic [1:0] CFG_SCALE  = 2'd1;
  localparam logic [1:0] CFG_OFFSET = 2'd2;

  localparam logic [7:0]  SETTLE_RST = 8'd5;
  localparam logic [15:0] SCALE_RST  = 16'd4800;
  localparam logic [11:0] OFFSET_RST = 12'd20;

  // Opcodes.
  localparam logic [1:0] OP_UPDATE    = 2'd0;
  localparam logic [1:0] OP_GET_FRAME = 2'd1;
  localparam logic [1:0] OP_LIVE      = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  // Scan phases.
  localparam logic [1:0] PH_ENABLE = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_SAMPLE = 2'd2;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [RAW_W-1:0]  raw_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/irsf_div.sv
// ----------------------------------------------------------------------------
// irsf_div: bit-serial restoring divider
// Produces one quotient bit per cycle; done pulses with the full quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module irsf_div
  import irsf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVR_W-1:0] rem_r, rem_nxt;
  logic [DVR_W-1:0] dvr_r;

  logic [DVR_W:0]   rem_sh;
  logic [DVR_W:0]   rem_sub;
  logic             ge;

  // The dividend shifts out of the top of quo_r while quotient bits enter
  // at the bottom.
  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvr_r};
  assign rem_sub = rem_sh - {1'b0, dvr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DVR_W-1:0] : rem_sh[DVR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvr_r <= req.divisor;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/ir_sensor_scan_filter.sv
// ----------------------------------------------------------------------------
// ir_sensor_scan_filter: three-sensor IR ranging scanner with moving average
// Steps a round-robin enable/settle/sample cycle, converts samples to UQ8.8
// distance and averages each sensor's recent distances.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                   Handshake
//  -------  --------------------------------------  ---------------------
//  in       in_opcode, in_now_ms, in_adc_sample     in_valid / in_ready
//  out      out_emitter_on ... out_right_raw        out_valid / out_ready
//  cfg      cfg_index, cfg_data                     cfg_we, no wait
//
//  A sampling update makes two passes through the one-bit-per-cycle divider,
//  one to convert the sample and one to average the history sum.
//  Every other word goes through ST_DONE to a valid result once out is free.
//  Reset is synchronous and clears the history valid bits at once.
//  A new word is taken while a finished result still waits on out_ready.
//
`default_nettype none

module ir_sensor_scan_filter
  import irsf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 4,
  parameter int SAMPLE_BITS   = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [TIME_W-1:0] in_now_ms,
  input  wire logic [RAW_W-1:0]  in_adc_sample,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_emitter_on,
  output logic                   out_frame_flag,
  output logic                   out_sample_taken,
  output logic [DIST_W-1:0]      out_front_distance,
  output logic [DIST_W-1:0]      out_left_distance,
  output logic [DIST_W-1:0]      out_right_distance,
  output logic [RAW_W-1:0]       out_front_raw,
  output logic [RAW_W-1:0]       out_left_raw,
  output logic [RAW_W-1:0]       out_right_raw,

  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int ENTRIES   = NUM_SENSORS * HISTORY_DEPTH;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int PTR_W     = $clog2(HISTORY_DEPTH);
  localparam int SCNT_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W     = DIST_W + $clog2(HISTORY_DEPTH);
  localparam int KEEP_BITS = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
  localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((32'd1 << KEEP_BITS) - 32'd1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_AVG  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // Configuration.
  logic [7:0]       settle_r;
  logic [15:0]      scale_r;
  logic [RAW_W-1:0] offset_r;

  // Scan state.
  logic [2:0]        state_r;
  logic [1:0]        phase_r;
  logic [1:0]        sel_r;
  logic [TIME_W-1:0] enable_time_r;
  logic [2:0]        emitter_r;
  logic              ready_flag_r;
  logic [1:0]        op_r;
  logic              taken_r;
  logic [RAW_W-1:0]  sample_r;
  logic [PTR_W-1:0]  hp_r [NUM_SENSORS];
  dist_t             live_dist_r  [NUM_SENSORS];
  raw_t              live_raw_r   [NUM_SENSORS];
  dist_t             frame_dist_r [NUM_SENSORS];
  raw_t              frame_raw_r  [NUM_SENSORS];

  // History memory with a valid bit per entry; an unwritten entry reads zero.
  dist_t             hist_mem [ENTRIES];
  logic [ENTRIES-1:0] hv_r;
  dist_t             rdata_r;
  logic              rvalid_r;
  dist_t             rd_val;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              wen;
  dist_t             dist_sat;

  logic [SCNT_W-1:0] scnt_r;
  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  sum_nxt;

  logic [1:0]        s_eff;
  logic [1:0]        s_next;
  logic [RAW_W-1:0]  sample_m;
  logic [TIME_W-1:0] elapsed;
  logic              accept;
  logic              out_free;
  logic              use_live;

  div_req_t div_req;
  div_rsp_t div_rsp;

  irsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign use_live = (op_r == OP_UPDATE) || (op_r == OP_LIVE);

  assign s_eff    = (sel_r == 2'd3) ? 2'd0 : sel_r;
  assign s_next   = (sel_r == 2'(NUM_SENSORS - 1)) ? 2'd0 : sel_r + 2'd1;
  assign sample_m = in_adc_sample & SAMPLE_MASK;
  assign elapsed  = in_now_ms - enable_time_r;

  assign base     = ADDR_W'(sel_r) * ADDR_W'(HISTORY_DEPTH);
  assign raddr    = (scnt_r < SCNT_W'(HISTORY_DEPTH)) ? base + ADDR_W'(scnt_r) : base;
  assign waddr    = base + ADDR_W'(hp_r[sel_r]);
  assign dist_sat = (div_rsp.quotient[DVD_W-1:DIST_W] != '0) ? '1
                                                             : div_rsp.quotient[DIST_W-1:0];
  assign wen      = (state_r == ST_CONV) && div_rsp.done;
  assign rd_val   = rvalid_r ? rdata_r : '0;
  assign sum_nxt  = acc_r + SUM_W'(rd_val);

  // The divider first converts the sample, then averages the history sum.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {scale_r, 8'h00};
    div_req.divisor  = {1'b0, sample_m} + {1'b0, offset_r};
    if (accept && in_opcode == OP_UPDATE && phase_r == PH_SAMPLE) begin
      div_req.start = 1'b1;
    end else if (state_r == ST_SUM && scnt_r == SCNT_W'(HISTORY_DEPTH)) begin
      div_req.start    = 1'b1;
      div_req.dividend = {{(DVD_W-SUM_W){1'b0}}, sum_nxt};
      div_req.divisor  = DVR_W'(HISTORY_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      hist_mem[waddr] <= dist_sat;
    end
    rdata_r  <= hist_mem[raddr];
    rvalid_r <= hv_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RST;
      scale_r  <= SCALE_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE: settle_r <= cfg_data[7:0];
        CFG_SCALE:  scale_r  <= cfg_data;
        CFG_OFFSET: offset_r <= cfg_data[RAW_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_ENABLE;
      sel_r         <= 2'd0;
      enable_time_r <= '0;
      emitter_r     <= 3'b000;
      ready_flag_r  <= 1'b0;
      op_r          <= OP_UPDATE;
      taken_r       <= 1'b0;
      scnt_r        <= '0;
      acc_r         <= '0;
      hv_r          <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        hp_r[i]         <= '0;
        live_dist_r[i]  <= '0;
        live_raw_r[i]   <= '0;
        frame_dist_r[i] <= '0;
        frame_raw_r[i]  <= '0;
      end
    end else begin
      // In ST_DONE a leaving word is replaced by the next one below.
      if (out_valid && out_ready && state_r != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r    <= in_opcode;
            taken_r <= 1'b0;
            state_r <= (in_opcode == OP_UPDATE && phase_r == PH_SAMPLE) ? ST_CONV
                                                                          : ST_DONE;
            if (in_opcode == OP_UPDATE) begin
              sel_r <= s_eff;
              case (phase_r)
                PH_ENABLE: begin
                  emitter_r     <= 3'(3'b001 << s_eff);
                  enable_time_r <= in_now_ms;
                  phase_r       <= PH_SETTLE;
                end
                PH_SETTLE: begin
                  if (elapsed >= TIME_W'(settle_r)) begin
                    phase_r <= PH_SAMPLE;
                  end
                end
                PH_SAMPLE: begin
                  sample_r <= sample_m;
                end
                default: phase_r <= PH_ENABLE;
              endcase
            end
          end
        end
        ST_CONV: begin
          if (div_rsp.done) begin
            hv_r[waddr] <= 1'b1;
            hp_r[sel_r] <= (hp_r[sel_r] == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                      : hp_r[sel_r] + 1'b1;
            scnt_r      <= '0;
            acc_r       <= '0;
            state_r     <= ST_SUM;
          end
        end
        ST_SUM: begin
          // Read data is registered behind its address, so the count runs one past.
          if (scnt_r != '0) begin
            acc_r <= sum_nxt;
          end
          scnt_r <= scnt_r + 1'b1;
          if (scnt_r == SCNT_W'(HISTORY_DEPTH)) begin
            state_r <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            live_dist_r[sel_r] <= div_rsp.quotient[DIST_W-1:0];
            live_raw_r[sel_r]  <= sample_r;
            emitter_r          <= 3'b000;
            taken_r            <= 1'b1;
            sel_r              <= s_next;
            phase_r            <= PH_ENABLE;
            state_r            <= ST_FIN;
          end
        end
        ST_FIN: begin
          // A completed sweep commits the live data as the frame.
          if (sel_r == 2'd0) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
              frame_dist_r[i] <= live_dist_r[i];
              frame_raw_r[i]  <= live_raw_r[i];
            end
            ready_flag_r <= 1'b1;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (op_r == OP_GET_FRAME) begin
              ready_flag_r <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_emitter_on     <= emitter_r;
      out_frame_flag     <= ready_flag_r;
      out_sample_taken   <= taken_r;
      out_front_distance <= use_live ? live_dist_r[0] : frame_dist_r[0];
      out_left_distance  <= use_live ? live_dist_r[1] : frame_dist_r[1];
      out_right_distance <= use_live ? live_dist_r[2] : frame_dist_r[2];
      out_front_raw      <= use_live ? live_raw_r[0]  : frame_raw_r[0];
      out_left_raw       <= use_live ? live_raw_r[1]  : frame_raw_r[1];
      out_right_raw      <= use_live ? live_raw_r[2]  : frame_raw_r[2];
    end
  end

  a_emitter_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(emitter_r))
    else $error("more than one emitter driven");

  a_taken_emitter_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_taken |-> out_emitter_on == 3'b000)
    else $error("emitter still on after a sampling word");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_commit_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && sel_r == 2'd0 |=> ready_flag_r)
    else $error("frame committed without setting the ready flag");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the three-sensor IR scan filter
// Walks a table of hand-picked words, then random update sequences under
// several calibration settings. Every result word is checked field by field
// against a scanner model kept in step inside this bench or a table row's expected word.
// ----------------------------------------------------------------------------

module testbench;
  import irsf_pkg::*;

  localparam int HIST_DEPTH   = 4;
  localparam int MAX_GAP      = 18;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 100;
  localparam int PHASE_WORDS  = 125;

  typedef struct packed {
    logic [2:0]                   emitter;
    logic                         ready;
    logic                         taken;
    dist_t [NUM_SENSORS-1:0]      distance;
    raw_t  [NUM_SENSORS-1:0]      raw;
  } reading_t;

  typedef struct {
    logic [1:0]        op;
    logic [TIME_W-1:0] now;
    raw_t              sample;
    bit                typed;
    reading_t          want;
  } scan_word_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_opcode;
  logic [TIME_W-1:0] in_now_ms;
  raw_t              in_adc_sample;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        out_emitter_on;
  logic              out_frame_flag;
  logic              out_sample_taken;
  dist_t             out_front_distance;
  dist_t             out_left_distance;
  dist_t             out_right_distance;
  raw_t              out_front_raw;
  raw_t              out_left_raw;
  raw_t              out_right_raw;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  ir_sensor_scan_filter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_now_ms          (in_now_ms),
    .in_adc_sample      (in_adc_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_emitter_on     (out_emitter_on),
    .out_frame_flag     (out_frame_flag),
    .out_sample_taken   (out_sample_taken),
    .out_front_distance (out_front_distance),
    .out_left_distance  (out_left_distance),
    .out_right_distance (out_right_distance),
    .out_front_raw      (out_front_raw),
    .out_left_raw       (out_left_raw),
    .out_right_raw      (out_right_raw),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Scanner model state and calibration.
  logic [7:0]        set_settle;
  logic [15:0]       set_scale;
  logic [11:0]       set_offset;
  logic [1:0]        ph;
  logic [1:0]        cur;
  logic [TIME_W-1:0] lit_at;
  logic [2:0]        lamps;
  dist_t             hist [NUM_SENSORS][HIST_DEPTH];
  int unsigned       hist_at [NUM_SENSORS];
  dist_t             live_d [NUM_SENSORS];
  dist_t             frame_d [NUM_SENSORS];
  raw_t              live_r [NUM_SENSORS];
  raw_t              frame_r [NUM_SENSORS];
  logic              flag_set;

  reading_t   due_readings [$];
  scan_word_t directed_words [$];
  int         mismatches    = 0;
  int         readings_seen = 0;
  bit         held_back     = 1'b0;
  bit         tx_burst      = 1'b0;
  bit         rx_burst      = 1'b0;
  string      SENSOR_NAME [NUM_SENSORS] = '{"front", "left", "right"};

  function automatic reading_t step_scanner(logic [1:0] op, logic [TIME_W-1:0] now,
                                            raw_t sample);
    reading_t    r;
    int unsigned s;
    logic [31:0] divisor;
    logic [31:0] quot;
    logic [31:0] sum;
    r = '0;
    s = (cur >= NUM_SENSORS) ? 0 : cur;
    if (op == OP_UPDATE) begin
      if (ph == PH_ENABLE) begin
        lamps  = 3'b001 << s;
        lit_at = now;
        ph     = PH_SETTLE;
      end else if (ph == PH_SETTLE) begin
        // Elapsed time wraps modulo 2^32.
        if (now - lit_at >= 32'(set_settle))
          ph = PH_SAMPLE;
      end else if (ph == PH_SAMPLE) begin
        live_r[s] = sample;
        lamps     = '0;
        divisor   = 32'(sample) + 32'(set_offset);
        if (divisor == 0) begin
          quot = 32'hFFFF;
        end else begin
          quot = {8'd0, set_scale, 8'd0} / divisor;
        end
        if (quot > 32'hFFFF)
          quot = 32'hFFFF;
        if (hist_at[s] >= HIST_DEPTH)
          hist_at[s] = 0;
        hist[s][hist_at[s]] = quot[15:0];
        hist_at[s] = (hist_at[s] + 1 >= HIST_DEPTH) ? 0 : hist_at[s] + 1;
        sum = 0;
        for (int i = 0; i < HIST_DEPTH; i++)
          sum += 32'(hist[s][i]);
        live_d[s] = dist_t'(sum / HIST_DEPTH);
        r.taken   = 1'b1;
        s = (s + 1 >= NUM_SENSORS) ? 0 : s + 1;
        // A completed sweep commits the live data as the new frame.
        if (s == 0) begin
          frame_d  = live_d;
          frame_r  = live_r;
          flag_set = 1'b1;
        end
        ph = PH_ENABLE;
      end else begin
        ph = PH_ENABLE;
      end
      cur = s[1:0];
    end
    r.emitter = lamps;
    r.ready   = flag_set;
    if (op == OP_GET_FRAME)
      flag_set = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (op == OP_UPDATE || op == OP_LIVE) begin
        r.distance[i] = live_d[i];
        r.raw[i]      = live_r[i];
      end else begin
        r.distance[i] = frame_d[i];
        r.raw[i]      = frame_r[i];
      end
    end
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [TIME_W-1:0] now, raw_t sample,
                                  bit typed, reading_t want);
    scan_word_t w;
    w.op     = op;
    w.now    = now;
    w.sample = sample;
    w.typed  = typed;
    w.want   = want;
    directed_words.push_back(w);
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic offer_word(logic [1:0] op, logic [TIME_W-1:0] now, raw_t sample,
                            bit typed, reading_t want);
    int unsigned gap;
    reading_t    pred;
    if ($urandom_range(0, 15) == 0)
      tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_now_ms     <= now;
    in_adc_sample <= sample;
    do @(posedge clk); while (!in_ready);
    pred = step_scanner(op, now, sample);
    due_readings.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Lets every outstanding word come back and the divider fall quiet.
  task automatic settle_down();
    in_valid <= 1'b0;
    while (due_readings.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_scanner(logic [7:0] settle, logic [15:0] scale,
                                 logic [11:0] offset);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SETTLE;
    cfg_data  <= CFG_W'(settle);
    @(negedge clk);
    cfg_index <= CFG_SCALE;
    cfg_data  <= scale;
    @(negedge clk);
    cfg_index <= CFG_OFFSET;
    cfg_data  <= CFG_W'(offset);
    @(negedge clk);
    cfg_we     <= 1'b0;
    set_settle = settle;
    set_scale  = scale;
    set_offset = offset;
  endtask

  // Mostly well-formed update runs with a steadily advancing tick, salted
  // with reads, flag queries and the odd wild timestamp.
  task automatic run_random(int words);
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] now;
    logic [1:0]        op;
    raw_t              sample;
    int unsigned       pick;
    reading_t          none;
    none = '0;
    tick = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 3000);
    repeat (words) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
        0:       sample = '0;
        1:       sample = '1;
        default: sample = raw_t'($urandom());
      endcase
      if (pick < 75) begin
        op = OP_UPDATE;
        if (pick < 4) begin
          now = $urandom();
        end else begin
          tick += $urandom_range(0, 32'(set_settle) * 3 / 2 + 2);
          now = tick;
        end
      end else begin
        op  = 2'($urandom_range(1, 3));
        now = $urandom();
      end
      offer_word(op, now, sample, 1'b0, none);
    end
  endtask

  // Result side.
  initial begin
    reading_t got;
    reading_t want;
    int unsigned hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (readings_seen == HOLD_AT && !held_back) begin
        // Long hold-off so that the block fills and stalls its input.
        held_back = 1'b1;
        hold = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 15) == 0)
          rx_burst = !rx_burst;
        hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.emitter     = out_emitter_on;
      got.ready       = out_frame_flag;
      got.taken       = out_sample_taken;
      got.distance[0] = out_front_distance;
      got.distance[1] = out_left_distance;
      got.distance[2] = out_right_distance;
      got.raw[0]      = out_front_raw;
      got.raw[1]      = out_left_raw;
      got.raw[2]      = out_right_raw;
      readings_seen++;
      if (due_readings.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing outstanding", $time);
      end else begin
        want = due_readings.pop_front();
        check_field("emitter_on", 32'(want.emitter), 32'(got.emitter));
        check_field("frame_flag", 32'(want.ready), 32'(got.ready));
        check_field("sample_taken", 32'(want.taken), 32'(got.taken));
        for (int i = 0; i < NUM_SENSORS; i++) begin
          check_field({SENSOR_NAME[i], "_distance"}, 32'(want.distance[i]),
                      32'(got.distance[i]));
          check_field({SENSOR_NAME[i], "_raw"}, 32'(want.raw[i]), 32'(got.raw[i]));
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    reading_t blank;
    reading_t front_lit;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_UPDATE;
    in_now_ms     = '0;
    in_adc_sample = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SETTLE;
    cfg_data      = '0;

    set_settle = SETTLE_RST;
    set_scale  = SCALE_RST;
    set_offset = OFFSET_RST;
    ph         = PH_ENABLE;
    cur        = '0;
    lit_at     = '0;
    lamps      = '0;
    flag_set   = 1'b0;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      hist_at[s] = 0;
      live_d[s]  = '0;
      live_r[s]  = '0;
      frame_d[s] = '0;
      frame_r[s] = '0;
      for (int i = 0; i < HIST_DEPTH; i++)
        hist[s][i] = '0;
    end

    blank             = '0;
    front_lit         = '0;
    front_lit.emitter = 3'b001;

    // Out of reset everything reads zero; the first update lights the front.
    add_row(OP_QUERY,     32'd0,         12'h000, 1'b1, blank);
    add_row(OP_LIVE,      32'hFFFF_FFFF, 12'hFFF, 1'b1, blank);
    add_row(OP_GET_FRAME, 32'd0,         12'h000, 1'b1, blank);
    add_row(OP_UPDATE,    32'hFFFF_FFFE, 12'hFFF, 1'b1, front_lit);
    // Settling across the tick wrap, then exactly on the delay.
    add_row(OP_UPDATE,    32'h0000_0001, 12'hFFF, 1'b0, blank);
    add_row(OP_UPDATE,    32'h0000_0003, 12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'h0000_0003, 12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'd1000,      12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'd1004,      12'h555, 1'b0, blank);
    add_row(OP_UPDATE,    32'd1005,      12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'd1005,      12'hFFF, 1'b0, blank);
    add_row(OP_LIVE,      32'd0,         12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'd5000,      12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'h8000_0000, 12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'h8000_0000, 12'hAAA, 1'b0, blank);
    // Flag: query leaves it, get_frame reports then clears it.
    add_row(OP_QUERY,     32'd0,         12'h000, 1'b0, blank);
    add_row(OP_GET_FRAME, 32'd0,         12'h000, 1'b0, blank);
    add_row(OP_QUERY,     32'd0,         12'h000, 1'b0, blank);
    add_row(OP_UPDATE,    32'd123,       12'h000, 1'b0, blank);
    add_row(OP_GET_FRAME, 32'h5555_5555, 12'h555, 1'b0, blank);
    add_row(OP_UPDATE,    32'hAAAA_AAAA, 12'hAAA, 1'b0, blank);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i])
      offer_word(directed_words[i].op, directed_words[i].now, directed_words[i].sample,
                 directed_words[i].typed, directed_words[i].want);

    // Extremes: no settling and saturated range, then longest settle and
    // smallest range, then a middle setting and back to the defaults.
    settle_down();
    program_scanner(8'd0, 16'hFFFF, 12'd1);
    run_random(PHASE_WORDS);
    settle_down();
    program_scanner(8'd255, 16'd1, 12'd4095);
    run_random(PHASE_WORDS);
    settle_down();
    program_scanner(8'd37, 16'd9000, 12'd300);
    run_random(PHASE_WORDS);
    settle_down();
    program_scanner(SETTLE_RST, SCALE_RST, OFFSET_RST);
    run_random(PHASE_WORDS);
    settle_down();

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/irsf_pkg.sv
rtl/irsf_div.sv
rtl/ir_sensor_scan_filter.sv
tb/testbench.sv
